// ===== rtl/cce_pkg.sv =====
// shared types, codes and constants of the text console cursor engine
package cce_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 4;

    // request field widths
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int TCOL_W  = 7;
    localparam int TROW_W  = 5;

    // result field widths
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 5;
    localparam int OOFF_W  = 11;
    localparam int CELL_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int COLOUR_W   = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;
    localparam logic [COLOUR_W-1:0]  FG_RESET = 4'd7;
    localparam logic [COLOUR_W-1:0]  BG_RESET = 4'd0;

    // command field widths, sized for the largest geometry
    localparam int CMD_COL_W  = 7;
    localparam int CMD_ROW_W  = 6;
    localparam int CMD_ADDR_W = 13;
    localparam int CMD_REP_W  = 4;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd3;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

    // cell fill values
    localparam logic [CELL_W-1:0] CLEAR_CELL  = 16'h0F00;
    localparam logic [CELL_W-1:0] SCROLL_FILL = 16'h0700;

    // classified operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OP_W-1:0] OP_BKSP  = 3'd1;
    localparam logic [OP_W-1:0] OP_NL    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_MOVE  = 3'd5;

    // one classified command
    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [CHAR_W-1:0]     ch;
        logic [CMD_REP_W-1:0]  rep;
        logic                  rd_ok;
        logic [CMD_ADDR_W-1:0] rd_addr;
        logic [CMD_COL_W-1:0]  col;
        logic [CMD_ROW_W-1:0]  row;
    } t_cmd;

endpackage

// ===== rtl/cce_ram.sv =====
// generic single write port ram with registered read
module cce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cce_front.sv =====
// front end: takes requests, classifies them and hands commands to the queue
module cce_front #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cce_pkg::MODE_W-1:0]    i_mode,
    input  logic [cce_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [cce_pkg::INDEX_W-1:0]   i_cell_index,
    input  logic [cce_pkg::TCOL_W-1:0]    i_target_column,
    input  logic [cce_pkg::TROW_W-1:0]    i_target_row,
    input  logic                          i_init_busy,
    output logic                          o_push,
    output cce_pkg::t_cmd                 o_cmd,
    input  logic                          i_q_full
);
    import cce_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // stall while the holding stage cannot drain or the store is being cleared after reset
    assign o_in_stall = (r_valid && i_q_full) || i_init_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_cmd      = r_cmd;

    // classify the request
    always_comb begin
        n_cmd         = '0;
        n_cmd.ch      = i_char_code;
        n_cmd.rep     = CMD_REP_W'(1);
        n_cmd.rd_ok   = int'(i_cell_index) < COLUMNS * ROWS;
        n_cmd.rd_addr = CMD_ADDR_W'(i_cell_index);
        n_cmd.col     = (int'(i_target_column) < COLUMNS) ? CMD_COL_W'(i_target_column)
                                                          : CMD_COL_W'(COLUMNS - 1);
        n_cmd.row     = (int'(i_target_row) < ROWS) ? CMD_ROW_W'(i_target_row)
                                                    : CMD_ROW_W'(ROWS - 1);
        unique case (i_mode)
            MODE_PUT: begin
                case (i_char_code)
                    CH_BACKSPACE: n_cmd.op = OP_BKSP;
                    CH_NEWLINE:   n_cmd.op = OP_NL;
                    CH_TAB: begin
                        n_cmd.op  = OP_PUT;
                        n_cmd.ch  = CH_SPACE;
                        n_cmd.rep = CMD_REP_W'(TAB_WIDTH);
                    end
                    default:      n_cmd.op = OP_PUT;
                endcase
            end
            MODE_CLEAR: n_cmd.op = OP_CLEAR;
            MODE_READ:  n_cmd.op = OP_READ;
            MODE_MOVE:  n_cmd.op = OP_MOVE;
            default:    n_cmd.op = OP_MOVE;
        endcase
    end

    // holding stage occupancy
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/cce_queue.sv =====
// short command queue between front and back end
module cce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cce_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output cce_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import cce_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Q_DEPTH - 1);

    t_cmd             r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = r_count == CNT_W'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/cce_back.sv =====
// back end: sequencer that carries out commands on the cell store
module cce_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_q_empty,
    input  cce_pkg::t_cmd                   i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_init_busy,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cce_pkg::OCOL_W-1:0]      o_cursor_column,
    output logic [cce_pkg::OROW_W-1:0]      o_cursor_row,
    output logic [cce_pkg::OOFF_W-1:0]      o_cursor_offset,
    output logic [cce_pkg::CELL_W-1:0]      o_read_data
);
    import cce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [AW-1:0] END_ADDR    = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_LAST = AW'(COLUMNS * (ROWS - 1) - 1);
    localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);

    // sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_INIT   = 4'd0;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd1;
    localparam logic [ST_W-1:0] S_PUT    = 4'd2;
    localparam logic [ST_W-1:0] S_BKSP   = 4'd3;
    localparam logic [ST_W-1:0] S_NL     = 4'd4;
    localparam logic [ST_W-1:0] S_SCROLL = 4'd5;
    localparam logic [ST_W-1:0] S_FILL   = 4'd6;
    localparam logic [ST_W-1:0] S_READ   = 4'd7;
    localparam logic [ST_W-1:0] S_DONE   = 4'd8;

    logic [ST_W-1:0]      r_state, n_state;
    logic [AW-1:0]        r_addr, n_addr;
    logic [CW-1:0]        r_col, n_col;
    logic [RW-1:0]        r_row, n_row;
    logic [CMD_REP_W-1:0] r_rep, n_rep;
    logic [CHAR_W-1:0]    r_ch, n_ch;
    logic                 r_rd_ok, n_rd_ok;
    logic                 r_clr_reply, n_clr_reply;
    logic                 r_cp_pend, n_cp_pend;
    logic [AW-1:0]        r_cp_addr, n_cp_addr;
    logic [CELL_W-1:0]    r_data, n_data;
    logic [COLOUR_W-1:0]  r_fg;
    logic [COLOUR_W-1:0]  r_bg;
    logic                 r_out_valid, n_out_valid;
    logic [OCOL_W-1:0]    r_out_col;
    logic [OROW_W-1:0]    r_out_row;
    logic [OOFF_W-1:0]    r_out_off;
    logic [CELL_W-1:0]    r_out_data;
    logic                 out_load;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;

    logic [AW-1:0]        cur_addr;
    logic [CW-1:0]        bk_col;
    logic [RW-1:0]        bk_row;
    logic [AW-1:0]        bk_addr;

    // cell store
    cce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // linear cursor position
    assign cur_addr = AW'(r_row * COLUMNS) + AW'(r_col);

    // cursor after a backspace step
    always_comb begin
        bk_col = r_col;
        bk_row = r_row;
        if (r_col != '0) begin
            bk_col = r_col - 1'b1;
        end else if (r_row != '0) begin
            bk_col = LAST_COL;
            bk_row = r_row - 1'b1;
        end
    end
    assign bk_addr = AW'(bk_row * COLUMNS) + AW'(bk_col);

    assign o_init_busy = (r_state == S_INIT) && !r_clr_reply;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_rep       = r_rep;
        n_ch        = r_ch;
        n_rd_ok     = r_rd_ok;
        n_clr_reply = r_clr_reply;
        n_cp_pend   = r_cp_pend;
        n_cp_addr   = r_cp_addr;
        n_data      = r_data;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cp_addr;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_addr + ROW_STEP;

        unique case (r_state)
            // clearing pass after reset and for the clear command
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = CLEAR_CELL;
                if (r_addr == END_ADDR) begin
                    n_addr  = '0;
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            // dispatch the next command
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop     = 1'b1;
                    n_ch        = i_q_cmd.ch;
                    n_rep       = '0;
                    n_data      = '0;
                    n_clr_reply = 1'b0;
                    unique case (i_q_cmd.op)
                        OP_PUT: begin
                            n_rep   = i_q_cmd.rep;
                            n_state = S_PUT;
                        end
                        OP_BKSP: n_state = S_BKSP;
                        OP_NL:   n_state = S_NL;
                        OP_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_addr      = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_INIT;
                        end
                        OP_READ: begin
                            ram_raddr = AW'(i_q_cmd.rd_addr);
                            n_rd_ok   = i_q_cmd.rd_ok;
                            n_state   = S_READ;
                        end
                        OP_MOVE: begin
                            n_col   = CW'(i_q_cmd.col);
                            n_row   = RW'(i_q_cmd.row);
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // write one character and advance
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {r_bg, r_fg, r_ch};
                n_rep     = r_rep - 1'b1;
                n_state   = (r_rep == CMD_REP_W'(1)) ? S_DONE : S_PUT;
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_addr  = '0;
                        n_state = S_SCROLL;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            // step back and blank the cell
            S_BKSP: begin
                ram_we    = 1'b1;
                ram_waddr = bk_addr;
                ram_wdata = {r_bg, r_fg, CH_NUL};
                n_col     = bk_col;
                n_row     = bk_row;
                n_state   = S_DONE;
            end
            // newline
            S_NL: begin
                n_col   = '0;
                n_state = S_DONE;
                if (r_row == LAST_ROW) begin
                    n_addr  = '0;
                    n_state = S_SCROLL;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            // copy each cell up one row, each write lands in the cycle after its read
            S_SCROLL: begin
                if (r_cp_pend) begin
                    ram_we = 1'b1;
                end
                n_cp_pend = 1'b1;
                n_cp_addr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == SCROLL_LAST) begin
                    n_state = S_FILL;
                end
            end
            // finish the last copy, then fill the bottom row
            S_FILL: begin
                ram_we = 1'b1;
                if (r_cp_pend) begin
                    n_cp_pend = 1'b0;
                end else begin
                    ram_waddr = r_addr;
                    ram_wdata = SCROLL_FILL;
                    if (r_addr == END_ADDR) begin
                        n_addr  = '0;
                        n_state = (r_rep != '0) ? S_PUT : S_DONE;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            // capture read data
            S_READ: begin
                n_data  = r_rd_ok ? ram_rdata : '0;
                n_state = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_rep       <= '0;
            r_clr_reply <= 1'b0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_rep       <= n_rep;
            r_clr_reply <= n_clr_reply;
            r_cp_pend   <= n_cp_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // colour registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FG:  r_fg <= COLOUR_W'(i_cfg_data);
                REG_BG:  r_bg <= COLOUR_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ch      <= n_ch;
        r_rd_ok   <= n_rd_ok;
        r_cp_addr <= n_cp_addr;
        r_data    <= n_data;
        if (out_load) begin
            r_out_col  <= OCOL_W'(r_col);
            r_out_row  <= OROW_W'(r_row);
            r_out_off  <= OOFF_W'(cur_addr);
            r_out_data <= r_data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cursor_offset = r_out_off;
    assign o_read_data     = r_out_data;

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// top level of the text console cursor engine
//
//  channel   direction  handshake                 payload
//  in        request    i_in_valid / o_in_stall   mode, char_code, cell_index, target col/row
//  out       result     o_out_valid / i_out_stall cursor column/row/offset, read_data
//  cfg       write      i_cfg_we                  i_cfg_index, i_cfg_data
//
// each command runs through the back-end sequencer, and a tab writes TAB_WIDTH spaces;
// each write goes through the single store write port
// a scroll copies every cell up one row and then fills the bottom row, and a clear
// writes every cell of the store
// after reset a clearing pass over every cell runs while o_in_stall is held high
// the front holds one request and the queue two commands, so input keeps flowing
// while the back end works or the output register is stalled, until both are full
module text_console_cursor_engine #(
    parameter int COLUMNS   = cce_pkg::DEF_COLUMNS,
    parameter int ROWS      = cce_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = cce_pkg::DEF_TAB_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cce_pkg::MODE_W-1:0]      i_mode,
    input  logic [cce_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [cce_pkg::INDEX_W-1:0]     i_cell_index,
    input  logic [cce_pkg::TCOL_W-1:0]      i_target_column,
    input  logic [cce_pkg::TROW_W-1:0]      i_target_row,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cce_pkg::OCOL_W-1:0]      o_cursor_column,
    output logic [cce_pkg::OROW_W-1:0]      o_cursor_row,
    output logic [cce_pkg::OOFF_W-1:0]      o_cursor_offset,
    output logic [cce_pkg::CELL_W-1:0]      o_read_data,
    input  logic                            i_cfg_we,
    input  logic [cce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cce_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cce_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_pop;
    t_cmd q_cmd;
    logic q_empty;
    logic init_busy;

    // request intake and classification
    cce_front #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_target_column (i_target_column),
        .i_target_row    (i_target_row),
        .i_init_busy     (init_busy),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_q_full        (q_full)
    );

    // command queue
    cce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    // command execution and result register
    cce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_empty       (q_empty),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_init_busy     (init_busy),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_offset (o_cursor_offset),
        .o_read_data     (o_read_data)
    );

endmodule
